// ----- hw/rtl/euler_angles_to_rotation_matrix_defines.svh -----
// Assertion macros used by the checker file.
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define EAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ear_pkg.sv -----
package ear_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int TURN_SHIFT  = 32 - ANGLE_WIDTH;

    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [15:0]            t_entry;

    typedef struct packed {
        t_angle angle_x;
        t_angle angle_y;
        t_angle angle_z;
    } t_in;

    typedef struct packed {
        t_entry r00;
        t_entry r01;
        t_entry r02;
        t_entry r10;
        t_entry r11;
        t_entry r12;
        t_entry r20;
        t_entry r21;
        t_entry r22;
    } t_out;

    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0] Q30_HALF     = 31'h2000_0000;
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [63:0] RECIP_NUM    = 64'h8000_0000;

    localparam int SERIES_STEPS = 6;
    localparam logic [7:0] K_COS [SERIES_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    // The sine series has one step less; its first divisor is never used.
    localparam logic [7:0] K_SIN [SERIES_STEPS] = '{8'd2, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    localparam int SIN_LAT = 3 + 3 * SERIES_STEPS + 1;
    localparam int MAT_LAT = 4;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } t_sm;

    typedef struct packed {
        logic [29:0] x;
        logic [29:0] x2;
        logic        use_cos;
        logic        neg;
    } t_sin_ctl;

    function automatic logic [31:0] to_turn(input t_angle a);
        logic [31:0] w;
        begin
            w = 32'($unsigned(a));
            return w << TURN_SHIFT;
        end
    endfunction

    function automatic t_sm smul(input t_sm a, input t_sm b);
        t_sm         r;
        logic [61:0] p;
        begin
            p     = 62'(a.mag) * 62'(b.mag) + 62'(Q30_HALF);
            r.neg = a.neg ^ b.neg;
            r.mag = 31'(p >> 30);
            return r;
        end
    endfunction

    function automatic logic signed [32:0] to_signed(input t_sm a);
        logic signed [32:0] v;
        begin
            v = $signed({2'b00, a.mag});
            return a.neg ? -v : v;
        end
    endfunction

endpackage

// ----- hw/rtl/ear_sine.sv -----
module ear_sine (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [31:0]   i_turn,
    output ear_pkg::t_sm  o_sine
);
    import ear_pkg::*;

    logic [30:0] u;
    logic        use_cos;
    logic [29:0] p;

    always_comb begin
        u       = i_turn[30] ? (Q30_ONE - {1'b0, i_turn[29:0]}) : {1'b0, i_turn[29:0]};
        use_cos = u > Q30_HALF;
        p       = use_cos ? 30'(Q30_ONE - u) : u[29:0];
    end

    logic [29:0] r0_p;
    logic        r0_cos;
    logic        r0_neg;
    logic [29:0] r1_x;
    logic        r1_cos;
    logic        r1_neg;
    t_sin_ctl    r2_ctl;
    logic [60:0] xprod;
    logic [60:0] x2prod;

    assign xprod  = 61'(r0_p) * 61'(HALF_PI_Q30) + 61'(Q30_HALF);
    assign x2prod = 61'(r1_x) * 61'(r1_x) + 61'(Q30_HALF);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_p           <= p;
            r0_cos         <= use_cos;
            r0_neg         <= i_turn[31];
            r1_x           <= 30'(xprod >> 30);
            r1_cos         <= r0_cos;
            r1_neg         <= r0_neg;
            r2_ctl.x       <= r1_x;
            r2_ctl.x2      <= 30'(x2prod >> 30);
            r2_ctl.use_cos <= r1_cos;
            r2_ctl.neg     <= r1_neg;
        end
    end

    logic [30:0] t_chain   [SERIES_STEPS+1];
    t_sin_ctl    ctl_chain [SERIES_STEPS+1];

    assign t_chain[0]   = Q30_ONE;
    assign ctl_chain[0] = r2_ctl;

    for (genvar s = 0; s < SERIES_STEPS; s++) begin : g_step
        localparam logic [7:0]  KC = K_COS[s];
        localparam logic [7:0]  KS = K_SIN[s];
        localparam logic [30:0] CC = 31'(RECIP_NUM / KC);
        localparam logic [30:0] CS = 31'(RECIP_NUM / KS);

        logic [30:0] ra_m;
        t_sin_ctl    ra_ctl;
        logic [30:0] rb_m;
        logic [30:0] rb_q0;
        t_sin_ctl    rb_ctl;
        logic [30:0] rc_t;
        t_sin_ctl    rc_ctl;

        logic [7:0]  ka;
        logic [61:0] na;
        logic [61:0] pb;
        logic [7:0]  kc;
        logic [31:0] rem;
        logic [30:0] q;
        logic [30:0] n_t;

        always_comb begin
            ka  = ctl_chain[s].use_cos ? KC : KS;
            na  = 62'(ctl_chain[s].x2) * 62'(t_chain[s]) + (62'(ka) << 29);
            pb  = 62'(ra_m) * 62'(ra_ctl.use_cos ? CC : CS);
            kc  = rb_ctl.use_cos ? KC : KS;
            rem = 32'(rb_m) - 32'(rb_q0) * 32'(kc);
            q   = (rem >= 32'(kc)) ? rb_q0 + 31'd1 : rb_q0;
            n_t = (q > Q30_ONE) ? 31'd0 : Q30_ONE - q;
            if (s == 0 && !rb_ctl.use_cos) begin
                n_t = Q30_ONE;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                ra_m   <= 31'(na >> 30);
                ra_ctl <= ctl_chain[s];
                rb_m   <= ra_m;
                rb_q0  <= 31'(pb >> 31);
                rb_ctl <= ra_ctl;
                rc_t   <= n_t;
                rc_ctl <= rb_ctl;
            end
        end

        assign t_chain[s+1]   = rc_t;
        assign ctl_chain[s+1] = rc_ctl;
    end

    logic [60:0] fprod;
    t_sin_ctl    fctl;

    assign fctl  = ctl_chain[SERIES_STEPS];
    assign fprod = 61'(fctl.x) * 61'(t_chain[SERIES_STEPS]) + 61'(Q30_HALF);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sine.neg <= fctl.neg;
            o_sine.mag <= fctl.use_cos ? t_chain[SERIES_STEPS] : 31'(fprod >> 30);
        end
    end

endmodule

// ----- hw/rtl/euler_angles_to_rotation_matrix.sv -----
// Rotation matrix R = Rz * Ry * Rx from three Euler angles.
// Input beat: three signed binary angles (half of the field range is pi).
// Output beat: the nine matrix entries, signed Q1.ENTRY_FRAC_BITS, rounded
// and saturated to plus or minus one.
// Both channels use valid and stall. A beat is taken when valid is high
// and stall is low.
// The sine and cosine pipelines are followed by the matrix products, sums
// and final rounding. One beat is accepted every cycle while the output is
// not stalled; the throughput is set by the fully pipelined datapath.
// When the receiver stalls while a result is waiting, the whole pipeline
// holds and the input stall is raised in the same cycle, so no beat is
// lost or repeated.
// Reset clears the valid bits of all stages; no data is kept between beats.
module euler_angles_to_rotation_matrix #(
    parameter int ENTRY_FRAC_BITS = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ear_pkg::t_in  i_in,
    output logic          o_valid,
    input  logic          i_stall,
    output ear_pkg::t_out o_res
);
    import ear_pkg::*;

    localparam int VLD_LEN = SIN_LAT + MAT_LAT;
    localparam int SH = 30 - ENTRY_FRAC_BITS;
    localparam logic [32:0] RND = 33'((64'd1 << SH) >> 1);
    localparam logic [32:0] LIM = 33'(64'd1 << ENTRY_FRAC_BITS);

    logic               en;
    logic [VLD_LEN-1:0] r_vld;

    assign o_valid = r_vld[VLD_LEN-1];
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VLD_LEN-2:0], i_valid};
        end
    end

    logic [31:0] turn [6];
    t_sm         trig [6];

    assign turn[0] = to_turn(i_in.angle_x);
    assign turn[1] = to_turn(i_in.angle_x) + QUARTER_TURN;
    assign turn[2] = to_turn(i_in.angle_y);
    assign turn[3] = to_turn(i_in.angle_y) + QUARTER_TURN;
    assign turn[4] = to_turn(i_in.angle_z);
    assign turn[5] = to_turn(i_in.angle_z) + QUARTER_TURN;

    for (genvar g = 0; g < 6; g++) begin : g_trig
        ear_sine u_sine (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_turn (turn[g]),
            .o_sine (trig[g])
        );
    end

    t_sm sx, cx, sy, cy, sz, cz;
    assign sx = trig[0];
    assign cx = trig[1];
    assign sy = trig[2];
    assign cy = trig[3];
    assign sz = trig[4];
    assign cz = trig[5];

    t_sm r1_czsy, r1_szsy, r1_czcy, r1_szcx, r1_szsx, r1_szcy;
    t_sm r1_czcx, r1_czsx, r1_cysx, r1_cycx, r1_sx, r1_cx, r1_nsy;
    t_sm r2_a, r2_b, r2_c, r2_d, r2_szcx, r2_szsx, r2_czcx, r2_czsx;
    t_sm r2_czcy, r2_szcy, r2_nsy, r2_cysx, r2_cycx;
    logic signed [32:0] r3_v [9];
    t_out r_out;

    function automatic t_entry finish(input logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] r;
        begin
            m = v[32] ? 33'(-v) : 33'(v);
            m = (m + RND) >> SH;
            if (m > LIM) begin
                m = LIM;
            end
            r = v[32] ? 33'(-m) : m;
            return r[15:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_czsy <= smul(cz, sy);
            r1_szsy <= smul(sz, sy);
            r1_czcy <= smul(cz, cy);
            r1_szcx <= smul(sz, cx);
            r1_szsx <= smul(sz, sx);
            r1_szcy <= smul(sz, cy);
            r1_czcx <= smul(cz, cx);
            r1_czsx <= smul(cz, sx);
            r1_cysx <= smul(cy, sx);
            r1_cycx <= smul(cy, cx);
            r1_sx   <= sx;
            r1_cx   <= cx;
            r1_nsy  <= '{neg: !sy.neg, mag: sy.mag};

            r2_a    <= smul(r1_czsy, r1_sx);
            r2_b    <= smul(r1_czsy, r1_cx);
            r2_c    <= smul(r1_szsy, r1_sx);
            r2_d    <= smul(r1_szsy, r1_cx);
            r2_szcx <= r1_szcx;
            r2_szsx <= r1_szsx;
            r2_czcx <= r1_czcx;
            r2_czsx <= r1_czsx;
            r2_czcy <= r1_czcy;
            r2_szcy <= r1_szcy;
            r2_nsy  <= r1_nsy;
            r2_cysx <= r1_cysx;
            r2_cycx <= r1_cycx;

            r3_v[0] <= to_signed(r2_czcy);
            r3_v[1] <= to_signed(r2_a) - to_signed(r2_szcx);
            r3_v[2] <= to_signed(r2_b) + to_signed(r2_szsx);
            r3_v[3] <= to_signed(r2_szcy);
            r3_v[4] <= to_signed(r2_c) + to_signed(r2_czcx);
            r3_v[5] <= to_signed(r2_d) - to_signed(r2_czsx);
            r3_v[6] <= to_signed(r2_nsy);
            r3_v[7] <= to_signed(r2_cysx);
            r3_v[8] <= to_signed(r2_cycx);

            r_out.r00 <= finish(r3_v[0]);
            r_out.r01 <= finish(r3_v[1]);
            r_out.r02 <= finish(r3_v[2]);
            r_out.r10 <= finish(r3_v[3]);
            r_out.r11 <= finish(r3_v[4]);
            r_out.r12 <= finish(r3_v[5]);
            r_out.r20 <= finish(r3_v[6]);
            r_out.r21 <= finish(r3_v[7]);
            r_out.r22 <= finish(r3_v[8]);
        end
    end

    assign o_res = r_out;

endmodule

// ----- hw/rtl/ear_checker.sv -----
`include "euler_angles_to_rotation_matrix_defines.svh"

module ear_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input ear_pkg::t_out o_res
);
    import ear_pkg::*;

    // The input side is held exactly while a finished beat waits.
    `EAR_ASSERT(a_stall_follows_output, i_clk, i_rst_n,
        o_stall == (o_valid && i_stall), "input stall does not follow a waiting output beat")

    `EAR_ASSERT(a_output_holds, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)), "stalled output beat changed")

    `EAR_ASSERT_ALWAYS(a_reset_clears_valid, i_clk,
        !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind euler_angles_to_rotation_matrix ear_checker u_ear_checker (.*);
